### src/lr_pkg.sv
package lr_pkg;

    localparam int COORD_W  = 10;
    localparam int ERR_W    = 11;
    localparam int LEFT_W   = 11;
    localparam int STEP_W   = 2;
    localparam int COLOR_W  = 8;
    localparam int SEG_W    = 16;
    localparam int OFFSET_W = 16;
    localparam int PROD_W   = 2 * COORD_W;

    localparam int SCREEN_WIDTH_DEF = 320;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Step directions as 2-bit two's complement codes.
    localparam logic [STEP_W-1:0] STEP_ZERO = 2'b00;
    localparam logic [STEP_W-1:0] STEP_POS  = 2'b01;
    localparam logic [STEP_W-1:0] STEP_NEG  = 2'b11;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] pen_color;
        logic [SEG_W-1:0]   frame_segment;
    } lr_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [OFFSET_W-1:0] pixel_offset;
        logic [COLOR_W-1:0]  pixel_color;
        logic [SEG_W-1:0]    pixel_segment;
        logic                last_pixel;
    } lr_pixel_t;

    // Decoded word passed from the front end to the stepping engine.
    typedef struct packed {
        logic               is_load;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [STEP_W-1:0]  diag_dx;
        logic [STEP_W-1:0]  diag_dy;
        logic [STEP_W-1:0]  straight_dx;
        logic [STEP_W-1:0]  straight_dy;
        logic [COORD_W-1:0] major_len;
        logic [COORD_W-1:0] minor_len;
        logic [ERR_W-1:0]   err_init;
        logic [COLOR_W-1:0] line_color;
        logic [SEG_W-1:0]   line_segment;
    } lr_cmd_t;

    function automatic logic [COORD_W-1:0] step_ext(input logic [STEP_W-1:0] code);
        step_ext = {{(COORD_W-STEP_W){code[STEP_W-1]}}, code};
    endfunction

    function automatic logic [STEP_W-1:0] sign_code(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
        if (b > a) begin
            sign_code = STEP_POS;
        end else if (b < a) begin
            sign_code = STEP_NEG;
        end else begin
            sign_code = STEP_ZERO;
        end
    endfunction

endpackage

### src/lr_front.sv
module lr_front import lr_pkg::*; (
    input  logic     s_valid,
    output logic     s_ready,
    input  lr_item_t s_item,
    input  logic     q_full,
    output logic     q_push,
    output lr_cmd_t  q_cmd
);

    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic               y_major;
    logic [STEP_W-1:0]  ddx;
    logic [STEP_W-1:0]  ddy;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        adx = (s_item.end_x >= s_item.start_x) ? s_item.end_x - s_item.start_x
                                                : s_item.start_x - s_item.end_x;
        ady = (s_item.end_y >= s_item.start_y) ? s_item.end_y - s_item.start_y
                                                : s_item.start_y - s_item.end_y;
        ddx = sign_code(s_item.start_x, s_item.end_x);
        ddy = sign_code(s_item.start_y, s_item.end_y);
        // Ties go to the y axis.
        y_major = (adx <= ady);

        q_cmd.is_load      = (s_item.mode == MODE_LOAD);
        q_cmd.start_x      = s_item.start_x;
        q_cmd.start_y      = s_item.start_y;
        q_cmd.diag_dx      = ddx;
        q_cmd.diag_dy      = ddy;
        q_cmd.straight_dx  = y_major ? STEP_ZERO : ddx;
        q_cmd.straight_dy  = y_major ? ddy : STEP_ZERO;
        q_cmd.major_len    = y_major ? ady : adx;
        q_cmd.minor_len    = y_major ? adx : ady;
        q_cmd.err_init     = {2'b00, q_cmd.major_len[COORD_W-1:1]};
        q_cmd.line_color   = s_item.pen_color;
        q_cmd.line_segment = s_item.frame_segment;
    end

endmodule

### src/lr_queue.sv
module lr_queue import lr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  lr_cmd_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output lr_cmd_t head
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lr_cmd_t          entry_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/lr_back.sv
module lr_back import lr_pkg::*; #(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  lr_cmd_t   q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output lr_pixel_t m_pixel
);

    localparam logic [COORD_W-1:0] WIDTH_C = COORD_W'(SCREEN_WIDTH);

    logic [COORD_W-1:0] cur_x_reg,       cur_x_next;
    logic [COORD_W-1:0] cur_y_reg,       cur_y_next;
    logic [ERR_W-1:0]   err_acc_reg,     err_acc_next;
    logic [COORD_W-1:0] major_len_reg;
    logic [COORD_W-1:0] minor_len_reg;
    logic [LEFT_W-1:0]  pixels_left_reg, pixels_left_next;
    logic [STEP_W-1:0]  diag_dx_reg;
    logic [STEP_W-1:0]  diag_dy_reg;
    logic [STEP_W-1:0]  straight_dx_reg;
    logic [STEP_W-1:0]  straight_dy_reg;
    logic [COLOR_W-1:0] line_color_reg;
    logic [SEG_W-1:0]   line_segment_reg;
    logic               busy_reg,        busy_next;
    logic               m_valid_reg,     m_valid_next;
    lr_pixel_t          m_pixel_reg,     m_pixel_next;

    logic               out_free;
    logic               emit;
    logic               is_load;
    logic [COORD_W-1:0] sel_x;
    logic [COORD_W-1:0] sel_y;
    logic [ERR_W-1:0]   sel_err;
    logic [COORD_W-1:0] sel_major;
    logic [COORD_W-1:0] sel_minor;
    logic [STEP_W-1:0]  sel_ddx;
    logic [STEP_W-1:0]  sel_ddy;
    logic [STEP_W-1:0]  sel_sdx;
    logic [STEP_W-1:0]  sel_sdy;
    logic [COLOR_W-1:0] sel_color;
    logic [SEG_W-1:0]   sel_seg;
    logic [ERR_W-1:0]   err_sum;
    logic               take_diag;
    logic               is_last;
    logic [PROD_W-1:0]  row_prod;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && out_free;
    assign is_load  = q_cmd.is_load;
    // A step word that arrives while no line is running is dropped.
    assign emit     = q_pop && (is_load || busy_reg);
    assign m_valid  = m_valid_reg;
    assign m_pixel  = m_pixel_reg;

    always_comb begin
        sel_x     = is_load ? q_cmd.start_x     : cur_x_reg;
        sel_y     = is_load ? q_cmd.start_y     : cur_y_reg;
        sel_err   = is_load ? q_cmd.err_init    : err_acc_reg;
        sel_major = is_load ? q_cmd.major_len   : major_len_reg;
        sel_minor = is_load ? q_cmd.minor_len   : minor_len_reg;
        sel_ddx   = is_load ? q_cmd.diag_dx     : diag_dx_reg;
        sel_ddy   = is_load ? q_cmd.diag_dy     : diag_dy_reg;
        sel_sdx   = is_load ? q_cmd.straight_dx : straight_dx_reg;
        sel_sdy   = is_load ? q_cmd.straight_dy : straight_dy_reg;
        sel_color = is_load ? q_cmd.line_color  : line_color_reg;
        sel_seg   = is_load ? q_cmd.line_segment : line_segment_reg;

        err_sum   = sel_err + {1'b0, sel_minor};
        take_diag = (err_sum >= {1'b0, sel_major});
        err_acc_next = take_diag ? err_sum - {1'b0, sel_major} : err_sum;
        cur_x_next = sel_x + step_ext(take_diag ? sel_ddx : sel_sdx);
        cur_y_next = sel_y + step_ext(take_diag ? sel_ddy : sel_sdy);

        if (is_load) begin
            is_last          = (q_cmd.major_len == '0);
            pixels_left_next = {1'b0, q_cmd.major_len};
        end else begin
            is_last          = (pixels_left_reg <= LEFT_W'(1));
            pixels_left_next = is_last ? '0 : pixels_left_reg - 1'b1;
        end
        busy_next = emit ? !is_last : busy_reg;

        row_prod = sel_y * WIDTH_C;
        m_pixel_next.pixel_x       = sel_x;
        m_pixel_next.pixel_y       = sel_y;
        m_pixel_next.pixel_offset  = row_prod[OFFSET_W-1:0] + OFFSET_W'(sel_x);
        m_pixel_next.pixel_color   = sel_color;
        m_pixel_next.pixel_segment = sel_seg;
        m_pixel_next.last_pixel    = is_last;

        m_valid_next = out_free ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            err_acc_reg     <= err_acc_next;
            pixels_left_reg <= pixels_left_next;
            m_pixel_reg     <= m_pixel_next;
        end
        if (q_pop && is_load) begin
            major_len_reg    <= q_cmd.major_len;
            minor_len_reg    <= q_cmd.minor_len;
            diag_dx_reg      <= q_cmd.diag_dx;
            diag_dy_reg      <= q_cmd.diag_dy;
            straight_dx_reg  <= q_cmd.straight_dx;
            straight_dy_reg  <= q_cmd.straight_dy;
            line_color_reg   <= q_cmd.line_color;
            line_segment_reg <= q_cmd.line_segment;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && is_load |=> m_valid_reg)
        else $error("load word did not produce a pixel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && !is_load && !busy_reg |=> !m_valid_reg)
        else $error("step word while idle produced a pixel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && is_last |=> !busy_reg)
        else $error("line still running after its last pixel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && is_load && q_cmd.major_len == '0 |=> m_pixel_reg.last_pixel)
        else $error("single point line not marked last");

endmodule

### src/line_rasterizer_core.sv
// Bresenham line generator with a pull interface.
// Input channel (s_valid, s_ready, s_item): a word with mode MODE_LOAD
// takes two endpoints, a pen color and a frame segment, and yields the
// first pixel of the line; a word with mode MODE_STEP yields the next
// pixel. A step word while no line is running yields nothing. A load
// word while a line runs drops that line and starts the new one.
// Result channel (m_valid, m_ready, m_pixel): one word per pixel with x,
// y, the byte offset y*SCREEN_WIDTH+x modulo 65536, color, segment and
// a last mark. A line gives max(|dx|,|dy|)+1 pixels.
// An accepted word is written into the queue; when the engine pops it,
// its pixel is written into the output register.
// Throughput: one word per cycle while the receiver takes pixels, set by
// the single add, compare and coordinate update of the stepping engine.
// A queue of QUEUE_DEPTH entries (two by default) decouples the decoder
// from the engine, and s_ready drops only when that queue is full. When
// the receiver stalls, the pixel is held in the output register and the
// queue fills, then s_ready goes low. A synchronous reset (aresetn low)
// empties the queue and the output register and leaves no line running.
module line_rasterizer_core import lr_pkg::*; #(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lr_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output lr_pixel_t m_pixel
);

    logic    q_full;
    logic    q_push;
    lr_cmd_t q_in;
    logic    q_pop;
    logic    q_valid;
    lr_cmd_t q_head;

    lr_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_in)
    );

    lr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    lr_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_pixel (m_pixel)
    );

endmodule
